>>> src/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int PAYLOAD_BYTES  = 512;
    localparam int PAYLOAD_SHIFT  = $clog2(PAYLOAD_BYTES);
    localparam int DEF_MAX_WINDOW = 32;
    localparam int CMD_FIFO_DEPTH = 2;

    localparam int SEQ_W    = 7;
    localparam int OFFSET_W = 16;
    localparam int LEN_W    = 10;
    localparam int KIND_W   = 3;
    localparam int LIMIT_W  = 4;

    localparam logic [7:0]         PKT_READ_REQ  = 8'd1;
    localparam logic [7:0]         PKT_ACK       = 8'd3;
    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 4'd5;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA     = 3'd0,
        KIND_ERROR    = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_ABORT    = 3'd3,
        KIND_BAD_TYPE = 3'd4
    } t_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

    // one queued job for the back end: a single status beat or a run of data beats
    typedef struct packed {
        logic              is_window;
        t_kind             kind;
        logic [SEQ_W-1:0]  first_seq;
        logic [SEQ_W-1:0]  last_seq;
        logic [SEQ_W-1:0]  final_index;
        logic [LEN_W-1:0]  final_length;
    } t_cmd;

endpackage

>>> src/gbn_if.sv
`timescale 1ns / 1ps

interface gbn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  packet_type;
    logic [7:0]  window_size;
    logic [15:0] file_size;
    logic        file_exists;
    logic [7:0]  ack_number;

    modport source (output valid, op, packet_type, window_size, file_size, file_exists,
                    ack_number, input ready);
    modport sink (input valid, op, packet_type, window_size, file_size, file_exists,
                  ack_number, output ready);
endinterface

interface gbn_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [6:0]  sequence_res;
    logic [15:0] byte_offset;
    logic [9:0]  payload_length;
    logic        last;

    modport source (output valid, kind, sequence_res, byte_offset, payload_length, last,
                    input ready);
    modport sink (input valid, kind, sequence_res, byte_offset, payload_length, last,
                  output ready);
endinterface

interface gbn_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> src/gbn_cmd_fifo.sv
`timescale 1ns / 1ps

module gbn_cmd_fifo
    import gbn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    t_cmd             r_mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(CMD_FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> src/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbn_in_if.sink     i_req,
    gbn_cfg_if.sink    i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = ((SEQ_W + 1 > WIN_W) ? SEQ_W + 1 : WIN_W) + 1;

    logic                r_active, n_active;
    logic [WIN_W-1:0]    r_win, n_win;
    logic [SEQ_W-1:0]    r_fidx, n_fidx;
    logic [LEN_W-1:0]    r_flen, n_flen;
    logic [SEQ_W:0]      r_next_seq, n_next_seq;   // highest ack + 1
    logic [LIMIT_W-1:0]  r_tcount, n_tcount;
    logic [LIMIT_W-1:0]  r_limit;

    logic                accept;
    logic                push;
    logic                mk_window;
    logic                advance;
    logic [WIN_W-1:0]    win_sat;
    logic [SUM_W-1:0]    end_sum;
    t_cmd                cmd;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept && push;
    assign o_cmd       = cmd;

    always_comb begin
        if (i_req.window_size > 8'(MAX_WINDOW)) begin
            win_sat = WIN_W'(MAX_WINDOW);
        end else if (i_req.window_size == '0) begin
            win_sat = WIN_W'(1);
        end else begin
            win_sat = WIN_W'(i_req.window_size);
        end
    end

    // ack only moves forward, stays inside the file and below the sequence range
    assign advance = ((i_req.ack_number >> SEQ_W) == '0)
                  && (i_req.ack_number <= {1'b0, r_fidx})
                  && (i_req.ack_number >= r_next_seq);

    always_comb begin
        n_active   = r_active;
        n_win      = r_win;
        n_fidx     = r_fidx;
        n_flen     = r_flen;
        n_next_seq = r_next_seq;
        n_tcount   = r_tcount;
        push       = 1'b0;
        mk_window  = 1'b0;
        cmd        = '0;
        cmd.kind   = KIND_DATA;
        case (i_req.op)
            OP_START: begin
                n_active = 1'b0;
                push     = 1'b1;
                if (i_req.packet_type != PKT_READ_REQ) begin
                    cmd.kind = KIND_BAD_TYPE;
                end else if (!i_req.file_exists) begin
                    cmd.kind = KIND_ERROR;
                end else begin
                    n_active   = 1'b1;
                    n_win      = win_sat;
                    n_fidx     = SEQ_W'(i_req.file_size >> PAYLOAD_SHIFT);
                    n_flen     = LEN_W'(i_req.file_size[PAYLOAD_SHIFT-1:0]);
                    n_next_seq = '0;
                    n_tcount   = '0;
                    mk_window  = 1'b1;
                end
            end
            OP_ACK: begin
                if (r_active) begin
                    push = 1'b1;
                    if (i_req.packet_type != PKT_ACK) begin
                        n_active = 1'b0;
                        cmd.kind = KIND_BAD_TYPE;
                    end else begin
                        if (advance) begin
                            n_next_seq = i_req.ack_number + 1'b1;
                            n_tcount   = '0;
                        end
                        if (n_next_seq == {1'b0, r_fidx} + 1'b1) begin
                            n_active = 1'b0;
                            cmd.kind = KIND_DONE;
                        end else begin
                            mk_window = 1'b1;
                        end
                    end
                end
            end
            OP_TIMEOUT: begin
                if (r_active) begin
                    push     = 1'b1;
                    n_tcount = r_tcount + 1'b1;
                    if (n_tcount >= r_limit) begin
                        n_active = 1'b0;
                        cmd.kind = KIND_ABORT;
                    end else begin
                        mk_window = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        end_sum = SUM_W'(n_next_seq) + SUM_W'(n_win) - 1'b1;
        cmd.is_window    = mk_window;
        cmd.first_seq    = n_next_seq[SEQ_W-1:0];
        cmd.last_seq     = (end_sum > SUM_W'(n_fidx)) ? n_fidx : end_sum[SEQ_W-1:0];
        cmd.final_index  = n_fidx;
        cmd.final_length = n_flen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_win      <= '0;
            r_fidx     <= '0;
            r_flen     <= '0;
            r_next_seq <= '0;
            r_tcount   <= '0;
            r_limit    <= TIMEOUT_RESET;
        end else begin
            if (accept) begin
                r_active   <= n_active;
                r_win      <= n_win;
                r_fidx     <= n_fidx;
                r_flen     <= n_flen;
                r_next_seq <= n_next_seq;
                r_tcount   <= n_tcount;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.data;
            end
        end
    end

endmodule

>>> src/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back
    import gbn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    gbn_out_if.source  o_res
);

    t_back_state         r_state, n_state;
    t_cmd                r_cmd;
    logic [SEQ_W-1:0]    r_seq;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [SEQ_W-1:0]    r_out_seq;
    logic [OFFSET_W-1:0] r_offset;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;

    logic                out_free;
    logic                load;
    logic                emit_last;

    assign out_free  = !r_out_valid || o_res.ready;
    assign emit_last = !r_cmd.is_window || (r_seq == r_cmd.last_seq);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = !i_empty;
            BK_EMIT: load  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_seq <= i_cmd.first_seq;
        end else if (load) begin
            r_seq <= r_seq + 1'b1;
        end
        if (load) begin
            r_last <= emit_last;
            if (r_cmd.is_window) begin
                r_kind    <= KIND_DATA;
                r_out_seq <= r_seq;
                r_offset  <= OFFSET_W'({r_seq, {PAYLOAD_SHIFT{1'b0}}});
                r_len     <= (r_seq == r_cmd.final_index) ? r_cmd.final_length
                                                          : LEN_W'(PAYLOAD_BYTES);
            end else begin
                r_kind    <= r_cmd.kind;
                r_out_seq <= '0;
                r_offset  <= '0;
                r_len     <= '0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_kind;
    assign o_res.sequence_res   = r_out_seq;
    assign o_res.byte_offset    = r_offset;
    assign o_res.payload_length = r_len;
    assign o_res.last           = r_last;

endmodule

>>> src/go_back_n_file_sender.sv
`timescale 1ns / 1ps

// Go-back-N sender control. Each event beat on i_req (start, ack, timeout) is
// decoded by the front end, which keeps the session state and queues at most one job in
// a two-entry command queue; the back end turns a job into result beats on
// o_res, one beat per cycle while o_res.ready holds. A status result (error,
// done, abort, bad type) is a single beat; a window of N data packets is N beats,
// at most MAX_WINDOW. Each job is first loaded from the queue, then emitted.
// The front end keeps taking events while the queue has room. i_cfg writes the
// 4-bit timeout limit (reset 5) and should only be used while the block is idle.
module go_back_n_file_sender
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbn_in_if.sink     i_req,
    gbn_cfg_if.sink    i_cfg,
    gbn_out_if.source  o_res
);

    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    gbn_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    gbn_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    gbn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
